/* rtl/core/ndr_pkg.sv */
package ndr_pkg;

  localparam int unsigned WordBits = 64;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_LEN    = 4'b0010,
    PH_OFF    = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       list_start;
  } in_word_t;

  typedef struct packed {
    logic [WordBits-1:0] start_cluster;
    logic [WordBits-1:0] run_clusters;
    logic                sparse;
    logic                end_of_list;
    logic                bad_header;
  } result_t;

  localparam logic [7:0] LowNibbleMask  = 8'h0F;
  localparam logic [7:0] HighNibbleMask = 8'hF0;

  // Sign-extend a little-endian offset of 1 to 7 bytes; 0 or 8 bytes pass through.
  function automatic logic [WordBits-1:0] sign_ext(input logic [WordBits-1:0] v,
                                                   input logic [3:0] nbytes);
    logic [WordBits-1:0] r;
    r = v;
    case (nbytes)
      4'd1: r = {{56{v[7]}},  v[7:0]};
      4'd2: r = {{48{v[15]}}, v[15:0]};
      4'd3: r = {{40{v[23]}}, v[23:0]};
      4'd4: r = {{32{v[31]}}, v[31:0]};
      4'd5: r = {{24{v[39]}}, v[39:0]};
      4'd6: r = {{16{v[47]}}, v[47:0]};
      4'd7: r = {{8{v[55]}},  v[55:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/ndr_in_stage.sv */
module ndr_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               stall,
  input  ndr_pkg::in_word_t  word,
  input  logic               ready,
  output logic               word_valid,
  output ndr_pkg::in_word_t  word_q
);
  import ndr_pkg::*;

  assign stall = word_valid && !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (!stall) begin
      word_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      word_q <= word;
    end
  end

endmodule

/* rtl/core/ndr_core.sv */
module ndr_core #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  ndr_pkg::in_word_t word,
  output logic              res_valid,
  output ndr_pkg::result_t  res
);
  import ndr_pkg::*;

  localparam logic [3:0] MaxBytes = 4'(MAX_FIELD_BYTES);

  phase_t              phase, phase_next;
  logic [3:0]          byte_index, byte_index_next;
  logic [3:0]          length_bytes, length_bytes_next;
  logic [3:0]          offset_bytes, offset_bytes_next;
  logic [WordBits-1:0] length_accum, length_accum_next;
  logic [WordBits-1:0] offset_accum, offset_accum_next;
  logic [WordBits-1:0] cluster_accum, cluster_accum_next;

  phase_t              cur_phase;
  logic [3:0]          lb, ob, idx_inc;
  logic [5:0]          shift;
  logic [WordBits-1:0] shifted, off_ext, sum;
  logic                sp;

  assign lb      = 4'(word.data_byte & LowNibbleMask);
  assign ob      = 4'((word.data_byte & HighNibbleMask) >> 4);
  assign shift   = {byte_index[2:0], 3'b000};
  assign shifted = {56'd0, word.data_byte} << shift;
  assign idx_inc = byte_index + 4'd1;

  assign off_ext = sign_ext(offset_accum | shifted, offset_bytes);
  assign sum     = cluster_accum + off_ext;

  always_comb begin
    cur_phase          = word.list_start ? PH_HEADER : phase;
    phase_next         = cur_phase;
    byte_index_next    = byte_index;
    length_bytes_next  = length_bytes;
    offset_bytes_next  = offset_bytes;
    length_accum_next  = length_accum;
    offset_accum_next  = offset_accum;
    cluster_accum_next = word.list_start ? '0 : cluster_accum;
    res_valid          = 1'b0;
    res                = '0;
    sp                 = 1'b1;
    unique case (cur_phase)
      PH_HEADER: begin
        byte_index_next   = '0;
        length_accum_next = '0;
        offset_accum_next = '0;
        if (word.data_byte == 8'd0) begin
          res_valid       = 1'b1;
          res.end_of_list = 1'b1;
          phase_next      = PH_IDLE;
        end else if (lb > MaxBytes || ob > MaxBytes) begin
          res_valid      = 1'b1;
          res.bad_header = 1'b1;
          phase_next     = PH_IDLE;
        end else begin
          length_bytes_next = lb;
          offset_bytes_next = ob;
          phase_next        = (lb != 4'd0) ? PH_LEN : PH_OFF;
        end
      end
      PH_LEN: begin
        length_accum_next = length_accum | shifted;
        byte_index_next   = idx_inc;
        if (idx_inc >= length_bytes) begin
          byte_index_next = '0;
          if (offset_bytes == 4'd0) begin
            res_valid         = 1'b1;
            res.run_clusters  = length_accum | shifted;
            res.sparse        = 1'b1;
            phase_next        = PH_HEADER;
          end else begin
            phase_next = PH_OFF;
          end
        end
      end
      PH_OFF: begin
        offset_accum_next = offset_accum | shifted;
        byte_index_next   = idx_inc;
        if (idx_inc >= offset_bytes) begin
          sp                 = (off_ext == '0);
          cluster_accum_next = sum;
          byte_index_next    = '0;
          res_valid          = 1'b1;
          res.run_clusters   = length_accum;
          res.sparse         = sp;
          res.start_cluster  = sp ? '0 : sum;
          phase_next         = PH_HEADER;
        end
      end
      PH_IDLE: begin
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    if (!take) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_index    <= '0;
      length_bytes  <= '0;
      offset_bytes  <= '0;
      length_accum  <= '0;
      offset_accum  <= '0;
      cluster_accum <= '0;
    end else if (take) begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      length_bytes  <= length_bytes_next;
      offset_bytes  <= offset_bytes_next;
      length_accum  <= length_accum_next;
      offset_accum  <= offset_accum_next;
      cluster_accum <= cluster_accum_next;
    end
  end

endmodule

/* rtl/core/ndr_out_stage.sv */
module ndr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ndr_pkg::result_t res,
  output logic             ready,
  output logic             valid,
  input  logic             stall,
  output ndr_pkg::result_t res_q
);
  import ndr_pkg::*;

  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

/* rtl/core/ntfs_data_run_decoder.sv */
// Run-list decoder: takes one run-list byte per word, with list_start marking
// the first header of a list, and emits one word per finished run (absolute
// start cluster, length, sparse flag), one for a zero header ending the list,
// and one for a header whose byte count exceeds MAX_FIELD_BYTES. Offsets of
// 1 to 7 bytes are sign-extended before being added to the running cluster.
// Throughput is one byte per cycle while data_stall is low; a byte is registered
// in the input register and decoded there against the decode state, and a run's
// result is loaded into the result register when its last byte leaves the input
// register. A stalled result holds the input register. Bytes after an end or error
// result are dropped until the next list_start.
module ntfs_data_run_decoder #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        list_start,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] start_cluster,
  output logic [63:0] run_clusters,
  output logic        sparse,
  output logic        end_of_list,
  output logic        bad_header
);
  import ndr_pkg::*;

  in_word_t in_word, word_q;
  logic     word_valid, core_ready, take, res_valid;
  result_t  res, res_q;

  assign in_word.data_byte  = data_byte;
  assign in_word.list_start = list_start;
  assign take               = word_valid && core_ready;

  ndr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .valid      (data_valid),
    .stall      (data_stall),
    .word       (in_word),
    .ready      (core_ready),
    .word_valid (word_valid),
    .word_q     (word_q)
  );

  ndr_core #(
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .word      (word_q),
    .res_valid (res_valid),
    .res       (res)
  );

  ndr_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (res_valid),
    .res   (res),
    .ready (core_ready),
    .valid (result_valid),
    .stall (result_stall),
    .res_q (res_q)
  );

  assign start_cluster = res_q.start_cluster;
  assign run_clusters  = res_q.run_clusters;
  assign sparse        = res_q.sparse;
  assign end_of_list   = res_q.end_of_list;
  assign bad_header    = res_q.bad_header;

endmodule

/* sim/tb_ntfs_data_run_decoder.sv */
module tb_ntfs_data_run_decoder;
  import ndr_pkg::*;

  localparam int FieldBytesMax = 8;

  class run_list_scoreboard;
    result_t     pending_runs[$];
    int          fails;
    phase_t      cur_phase;
    logic [3:0]  byte_idx;
    logic [3:0]  len_cnt;
    logic [3:0]  off_cnt;
    logic [63:0] len_acc;
    logic [63:0] off_acc;
    logic [63:0] cluster;

    function new();
      fails     = 0;
      cur_phase = PH_HEADER;
      byte_idx  = '0;
      len_cnt   = '0;
      off_cnt   = '0;
      len_acc   = '0;
      off_acc   = '0;
      cluster   = '0;
    endfunction

    function int pending();
      return pending_runs.size();
    endfunction

    function logic [63:0] widen_offset(logic [63:0] v, logic [3:0] n);
      logic [63:0] mask;
      if (n >= 1 && n < 8) begin
        mask = ~(64'hFFFF_FFFF_FFFF_FFFF << (8 * n));
        v = v & mask;
        if (v[8 * n - 1]) v = v | ~mask;
      end
      return v;
    endfunction

    function void push_run(logic [63:0] sc, logic [63:0] rc, logic sp, logic eol,
                           logic bad);
      result_t r;
      r.start_cluster = sc;
      r.run_clusters  = rc;
      r.sparse        = sp;
      r.end_of_list   = eol;
      r.bad_header    = bad;
      pending_runs = {pending_runs, r};
    endfunction

    function void close_run();
      logic [63:0] off;
      logic        sp;
      off = '0;
      sp  = 1'b1;
      if (off_cnt != 0) begin
        off = widen_offset(off_acc, off_cnt);
        sp  = (off == 0);
      end
      cluster = cluster + off;
      push_run(sp ? 64'd0 : cluster, len_acc, sp, 1'b0, 1'b0);
      cur_phase = PH_HEADER;
      byte_idx  = '0;
    endfunction

    function void take_byte(logic [7:0] b, logic ls);
      logic [3:0] lb;
      logic [3:0] ob;
      lb = 4'(b & LowNibbleMask);
      ob = 4'((b & HighNibbleMask) >> 4);
      if (ls) begin
        cluster   = '0;
        cur_phase = PH_HEADER;
      end
      case (cur_phase)
        PH_HEADER: begin
          byte_idx = '0;
          len_acc  = '0;
          off_acc  = '0;
          if (b == 0) begin
            push_run('0, '0, 1'b0, 1'b1, 1'b0);
            cur_phase = PH_IDLE;
          end else if (lb > FieldBytesMax || ob > FieldBytesMax) begin
            push_run('0, '0, 1'b0, 1'b0, 1'b1);
            cur_phase = PH_IDLE;
          end else begin
            len_cnt   = lb;
            off_cnt   = ob;
            cur_phase = (lb != 0) ? PH_LEN : PH_OFF;
          end
        end
        PH_LEN: begin
          len_acc  = len_acc | (64'(b) << (8 * byte_idx[2:0]));
          byte_idx = byte_idx + 4'd1;
          if (byte_idx >= len_cnt) begin
            byte_idx = '0;
            if (off_cnt == 0) close_run();
            else cur_phase = PH_OFF;
          end
        end
        PH_OFF: begin
          off_acc  = off_acc | (64'(b) << (8 * byte_idx[2:0]));
          byte_idx = byte_idx + 4'd1;
          if (byte_idx >= off_cnt) close_run();
        end
        default: ;
      endcase
    endfunction

    function void check_run(result_t act);
      result_t exp;
      if (pending_runs.size() == 0) begin
        $error("result word with no expectation: start_cluster %h run_clusters %h",
               act.start_cluster, act.run_clusters);
        fails++;
        return;
      end
      exp = pending_runs.pop_front();
      if (act.start_cluster !== exp.start_cluster) begin
        $error("start_cluster: expected %h, actual %h", exp.start_cluster, act.start_cluster);
        fails++;
      end
      if (act.run_clusters !== exp.run_clusters) begin
        $error("run_clusters: expected %h, actual %h", exp.run_clusters, act.run_clusters);
        fails++;
      end
      if (act.sparse !== exp.sparse) begin
        $error("sparse: expected %b, actual %b", exp.sparse, act.sparse);
        fails++;
      end
      if (act.end_of_list !== exp.end_of_list) begin
        $error("end_of_list: expected %b, actual %b", exp.end_of_list, act.end_of_list);
        fails++;
      end
      if (act.bad_header !== exp.bad_header) begin
        $error("bad_header: expected %b, actual %b", exp.bad_header, act.bad_header);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        list_start = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [63:0] start_cluster;
  logic [63:0] run_clusters;
  logic        sparse;
  logic        end_of_list;
  logic        bad_header;

  run_list_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int bytes_sent = 0;

  ntfs_data_run_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .list_start   (list_start),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .start_cluster(start_cluster),
    .run_clusters (run_clusters),
    .sparse       (sparse),
    .end_of_list  (end_of_list),
    .bad_header   (bad_header)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && data_valid && !data_stall) sb.take_byte(data_byte, list_start);
  end

  always @(posedge clk) begin
    result_t act;
    if (!rst && result_valid && !result_stall) begin
      act.start_cluster = start_cluster;
      act.run_clusters  = run_clusters;
      act.sparse        = sparse;
      act.end_of_list   = end_of_list;
      act.bad_header    = bad_header;
      sb.check_run(act);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ls, input bit counted = 1'b1);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    list_start <= ls;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    if (counted) bytes_sent++;
  endtask

  // Header plus up to keep body bytes; keep below lb+ob leaves the entry unfinished.
  task automatic send_entry(input int lb, input int ob, input int keep, inout bit first);
    logic [63:0] len_v;
    logic [63:0] off_v;
    int          k;
    len_v = {$urandom(), $urandom()};
    off_v = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: off_v = '0;
      1: off_v = ~64'd0;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) len_v = len_v >> (8 * $urandom_range(1, 7));
    send_byte({4'(ob), 4'(lb)}, first);
    first = 1'b0;
    for (k = 0; k < lb + ob && k < keep; k++) begin
      if (k < lb) send_byte(8'(len_v >> (8 * k)), 1'b0);
      else send_byte(8'(off_v >> (8 * (k - lb))), 1'b0);
    end
  endtask

  function automatic int pick_count();
    if ($urandom_range(0, 3) == 0) return $urandom_range(5, 8);
    return $urandom_range(0, 4);
  endfunction

  task automatic send_list();
    int n;
    int i;
    int lb;
    int ob;
    int sel;
    bit first;
    logic [3:0] lo;
    logic [3:0] hi;
    first = 1'b1;
    n = $urandom_range(0, 6);
    for (i = 0; i < n; i++) begin
      lb = pick_count();
      ob = pick_count();
      if (lb == 0 && ob == 0) lb = 1;
      send_entry(lb, ob, lb + ob, first);
    end
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      send_byte(8'h00, first);
    end else if (sel < 82) begin
      lo = 4'($urandom_range(0, 15));
      hi = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 1)) lo = 4'($urandom_range(9, 15));
      else hi = 4'($urandom_range(9, 15));
      send_byte({hi, lo}, first);
    end else begin
      // unfinished entry, dropped by the next list start
      lb = pick_count();
      ob = pick_count();
      if (lb == 0 && ob == 0) ob = 1;
      send_entry(lb, ob, $urandom_range(0, lb + ob - 1), first);
      return;
    end
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) send_byte(8'($urandom()), 1'b0, 1'b0);
  endtask

  initial begin
    int p;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 19;
    rx_idle_pct = 88;
    send_byte(8'h11, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h21, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h18, 1'b1);
    repeat (8) send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hF1, 1'b0);
    send_byte(8'h19, 1'b1);
    send_byte(8'h00, 1'b1);

    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin tx_idle_pct = 19; rx_idle_pct = 88; end
        1: begin tx_idle_pct = 88; rx_idle_pct = 19; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      while (bytes_sent < 25 + (p + 1) * 625) send_list();
    end
    data_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ndr_pkg.sv
rtl/core/ndr_in_stage.sv
rtl/core/ndr_core.sv
rtl/core/ndr_out_stage.sv
rtl/core/ntfs_data_run_decoder.sv
sim/tb_ntfs_data_run_decoder.sv
